// ===== hdl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Used by dq_cell and double_ended_queue_top; depends on nothing.
`default_nettype none

package dq_pkg;

   // Request codes on req_operation
   typedef enum logic [1:0] {
      OP_PUSH_LEFT  = 2'd0,
      OP_PUSH_RIGHT = 2'd1,
      OP_POP_LEFT   = 2'd2,
      OP_POP_RIGHT  = 2'd3
   } op_type;

   // Completion codes on rsp_status
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic shift_right;   // push left: every word moves one cell right
      logic shift_left;    // pop left: every word moves one cell left
      logic push_tail;     // push right: first empty cell takes the word
      logic pop_tail;      // pop right: last full cell empties
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/dq_cell.sv =====
// One storage cell of the deque chain: a word and its occupied flag.
// Depends on dq_pkg for the command struct.
`default_nettype none

module dq_cell #(
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dq_pkg::cell_ctrl_type   ctrl,
   input  wire logic [WORD_WIDTH-1:0]   push_word,
   input  wire logic [WORD_WIDTH-1:0]   left_data,
   input  wire logic                    left_valid,
   input  wire logic [WORD_WIDTH-1:0]   right_data,
   input  wire logic                    right_valid,
   output logic      [WORD_WIDTH-1:0]   data_ff,
   output logic                         valid_ff,
   output logic      [WORD_WIDTH-1:0]   tail_tap
);

   logic [WORD_WIDTH-1:0] data_in;
   logic                  valid_in;
   logic                  is_tail;

   // this cell holds the rightmost word
   assign is_tail  = valid_ff & ~right_valid;
   assign tail_tap = is_tail ? data_ff : '0;

   // next contents from the command and the two neighbors
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.shift_right) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.shift_left) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.push_tail && !valid_ff && left_valid) begin
         data_in  = push_word;
         valid_in = 1'b1;
      end else if (ctrl.pop_tail && is_tail) begin
         valid_in = 1'b0;
      end
   end

   // occupied flag is control, word is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_top.sv =====
// Double-ended queue top level: a row of dq_cell stages plus the response register.
// Depends on dq_pkg and dq_cell.
//
// The queue holds up to DEPTH words, left-justified in a row of cells: cell 0 is
// always the left end, and each cell knows whether it is the right end from its
// own flag and its right neighbor's. A push or pop at the left shifts the whole
// row one cell at once; a push or pop at the right touches only the boundary
// cell. Each request updates the cells when it is taken, and its response appears
// in the output register on the next cycle; a new request is taken every cycle
// unless the response side stalls with a response still held. A refused push
// (queue full) or pop (queue empty) leaves the contents untouched.
`default_nettype none

module double_ended_queue_top #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_push_word,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [31:0] rsp_pop_word,
   output logic      [1:0]  rsp_status,
   output logic      [4:0]  rsp_fill_level
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [WORD_WIDTH-1:0] cell_data  [DEPTH];
   logic [WORD_WIDTH-1:0] cell_tap   [DEPTH];
   logic [DEPTH-1:0]      cell_valid;

   logic [63:0]           push_ext;
   logic [WORD_WIDTH-1:0] push_word;
   logic [WORD_WIDTH-1:0] tail_word;
   logic [WORD_WIDTH-1:0] pop_word;
   logic [63:0]           pop_ext;
   logic [31:0]           count_ext;

   dq_pkg::op_type        op;
   dq_pkg::cell_ctrl_type ctrl;
   dq_pkg::status_type    status;
   logic                  accept;
   logic                  full;
   logic                  empty;

   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_pop_word_ff, rsp_pop_word_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [4:0]            rsp_fill_level_ff, rsp_fill_level_in;

   // request handshake: the output register frees up when its response leaves
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign op        = dq_pkg::op_type'(req_operation);
   assign push_ext  = 64'(req_push_word);
   assign push_word = push_ext[WORD_WIDTH-1:0];
   assign full      = cell_valid[DEPTH-1];
   assign empty     = ~cell_valid[0];

   // decode the request into a chain command and a status
   always_comb begin
      ctrl     = '0;
      status   = dq_pkg::ST_DONE;
      count_in = count_ff;
      case (op)
         dq_pkg::OP_PUSH_LEFT, dq_pkg::OP_PUSH_RIGHT: begin
            if (full) begin
               status = dq_pkg::ST_OVERFLOW;
            end else begin
               ctrl.shift_right = accept & (op == dq_pkg::OP_PUSH_LEFT);
               ctrl.push_tail   = accept & (op == dq_pkg::OP_PUSH_RIGHT);
               count_in         = count_ff + CW'(1);
            end
         end
         dq_pkg::OP_POP_LEFT, dq_pkg::OP_POP_RIGHT: begin
            if (empty) begin
               status = dq_pkg::ST_UNDERFLOW;
            end else begin
               ctrl.shift_left = accept & (op == dq_pkg::OP_POP_LEFT);
               ctrl.pop_tail   = accept & (op == dq_pkg::OP_POP_RIGHT);
               count_in        = count_ff - CW'(1);
            end
         end
         default: begin
            status = dq_pkg::ST_DONE;
         end
      endcase
   end

   // the cell chain; cell 0 sees the incoming word as its left neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] l_data, r_data;
      logic                  l_valid, r_valid;

      if (i == 0) begin : g_first
         assign l_data  = push_word;
         assign l_valid = 1'b1;
      end else begin : g_inner_l
         assign l_data  = cell_data[i-1];
         assign l_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_data  = '0;
         assign r_valid = 1'b0;
      end else begin : g_inner_r
         assign r_data  = cell_data[i+1];
         assign r_valid = cell_valid[i+1];
      end

      dq_cell #(
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_word   (push_word),
         .left_data   (l_data),
         .left_valid  (l_valid),
         .right_data  (r_data),
         .right_valid (r_valid),
         .data_ff     (cell_data[i]),
         .valid_ff    (cell_valid[i]),
         .tail_tap    (cell_tap[i])
      );
   end

   // at most one cell drives its tap: the right end, when the queue is not empty
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | cell_tap[i];
      end
   end

   // response fields
   always_comb begin
      pop_word = '0;
      if (status == dq_pkg::ST_DONE && op == dq_pkg::OP_POP_LEFT) begin
         pop_word = cell_data[0];
      end else if (status == dq_pkg::ST_DONE && op == dq_pkg::OP_POP_RIGHT) begin
         pop_word = tail_word;
      end
   end

   assign pop_ext           = 64'(pop_word);
   assign count_ext         = 32'(count_in);
   assign rsp_pop_word_in   = accept ? pop_ext[31:0] : rsp_pop_word_ff;
   assign rsp_status_in     = accept ? status : rsp_status_ff;
   assign rsp_fill_level_in = accept ? count_ext[4:0] : rsp_fill_level_ff;
   assign rsp_valid_in      = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pop_word_ff   <= rsp_pop_word_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_fill_level_ff <= rsp_fill_level_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pop_word   = rsp_pop_word_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_level = rsp_fill_level_ff;

   // occupied cells always form a solid run starting at cell 0
   a_solid_run: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}))
      else $error("occupied cells are not contiguous from the left end");

   // the word count tracks the occupied cells
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == 32'($countones(cell_valid)))
      else $error("word count disagrees with occupied cells");

   // a refused request leaves the contents alone
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      accept && status != dq_pkg::ST_DONE |=> $stable(cell_valid))
      else $error("refused request changed the queue");

   // a pop that succeeds takes one word out
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && status == dq_pkg::ST_DONE && req_operation[1]
      |=> count_ff == $past(count_ff) - CW'(1))
      else $error("successful pop did not remove one word");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_top: directed and random pushes and pops at
// both ends, each response checked against a deque model kept inside the bench.
// Depends on dq_pkg and double_ended_queue_top.

module tb;

   localparam int DEPTH           = 16;
   localparam int RANDOM_REQUESTS = 1200;
   localparam int PHASE_LEN       = 410;
   localparam int STUCK_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 20;

   typedef struct packed {
      dq_pkg::op_type op;
      logic [31:0]    word;
   } dq_request_type;

   typedef struct packed {
      logic [31:0]        pop_word;
      dq_pkg::status_type status;
      logic [4:0]         fill_level;
   } dq_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = 2'd0;
   logic [31:0] req_push_word = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pop_word;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_fill_level;

   // Bench copy of the deque contents
   logic [31:0] deque_slots [DEPTH];
   logic [3:0]  left_index = 4'd0;
   logic [4:0]  word_total = 5'd0;

   dq_request_type  pending_requests [$];
   dq_response_type expected_responses [$];

   int              total_requests = 0;
   int              requests_accepted = 0;
   int              failures = 0;
   int              stuck_cycles = 0;
   int              sender_idle_pct;
   int              receiver_idle_pct;
   dq_request_type  next_request;
   dq_response_type want;

   double_ended_queue_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_push_word  (req_push_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pop_word   (rsp_pop_word),
      .rsp_status     (rsp_status),
      .rsp_fill_level (rsp_fill_level)
   );

   always #2 clock = ~clock;

   // Apply one request to the bench deque and return the response it must produce
   function automatic dq_response_type apply_deque_request(dq_pkg::op_type op,
                                                           logic [31:0] word);
      dq_response_type r;
      logic [3:0] slot;
      r.pop_word = 32'd0;
      r.status   = dq_pkg::ST_DONE;
      case (op)
         dq_pkg::OP_PUSH_LEFT, dq_pkg::OP_PUSH_RIGHT: begin
            if (word_total == DEPTH) begin
               r.status = dq_pkg::ST_OVERFLOW;
            end else begin
               if (op == dq_pkg::OP_PUSH_LEFT) begin
                  left_index = left_index - 4'd1;
                  slot = left_index;
               end else begin
                  slot = left_index + word_total[3:0];
               end
               deque_slots[slot] = word;
               word_total = word_total + 5'd1;
            end
         end
         default: begin
            if (word_total == 0) begin
               r.status = dq_pkg::ST_UNDERFLOW;
            end else begin
               if (op == dq_pkg::OP_POP_LEFT) begin
                  slot = left_index;
                  left_index = left_index + 4'd1;
               end else begin
                  // 4-bit wrap: a full queue has its right end just left of left_index
                  slot = left_index + word_total[3:0] - 4'd1;
               end
               r.pop_word = deque_slots[slot];
               word_total = word_total - 5'd1;
            end
         end
      endcase
      r.fill_level = word_total;
      return r;
   endfunction

   task automatic add_request(dq_pkg::op_type op, logic [31:0] word);
      dq_request_type r;
      r.op   = op;
      r.word = word;
      pending_requests.push_back(r);
   endtask

   // Idle rates: sender light / receiver heavy, then swapped, then none
   always_comb begin
      case (requests_accepted / PHASE_LEN)
         0:       begin sender_idle_pct = 11; receiver_idle_pct = 68; end
         1:       begin sender_idle_pct = 68; receiver_idle_pct = 11; end
         default: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
      endcase
   end

   // Stimulus, reset and end of run
   initial begin
      int             mode;
      int             seg_left;
      int             pick;
      bit             is_push;
      bit             side;
      dq_pkg::op_type op;
      logic [31:0]    w;

      // empty pops, single-word pops from the opposite end
      add_request(dq_pkg::OP_POP_LEFT, 32'h1234_5678);
      add_request(dq_pkg::OP_POP_RIGHT, 32'hFFFF_FFFF);
      add_request(dq_pkg::OP_PUSH_LEFT, 32'hFFFF_FFFF);
      add_request(dq_pkg::OP_POP_RIGHT, 32'd0);
      add_request(dq_pkg::OP_PUSH_RIGHT, 32'd0);
      add_request(dq_pkg::OP_POP_LEFT, 32'd0);
      // fill from both ends, then push into a full queue at each end
      for (int i = 0; i < DEPTH; i++) begin
         w = i[1] ? (32'hFFFF_FFFF ^ i) : (32'hA5A5_0000 | i);
         add_request(i[0] ? dq_pkg::OP_PUSH_RIGHT : dq_pkg::OP_PUSH_LEFT, w);
      end
      add_request(dq_pkg::OP_PUSH_LEFT, 32'hDEAD_BEEF);
      add_request(dq_pkg::OP_PUSH_RIGHT, 32'h0BAD_F00D);

      // random walk biased toward filling, draining or neither, per segment
      seg_left = 0;
      mode = 0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (seg_left == 0) begin
            mode = $urandom_range(2, 0);
            seg_left = $urandom_range(40, 8);
         end
         seg_left--;
         pick = $urandom_range(99, 0);
         is_push = (mode == 0) ? (pick < 75) : (mode == 1) ? (pick < 25) : (pick < 50);
         side = 1'($urandom_range(1, 0));
         if (is_push) op = side ? dq_pkg::OP_PUSH_RIGHT : dq_pkg::OP_PUSH_LEFT;
         else         op = side ? dq_pkg::OP_POP_RIGHT : dq_pkg::OP_POP_LEFT;
         case ($urandom_range(7, 0))
            0:       w = 32'd0;
            1:       w = 32'hFFFF_FFFF;
            default: w = $urandom;
         endcase
         add_request(op, w);
      end
      total_requests = pending_requests.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (requests_accepted < total_requests || expected_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Request driver: hold the payload while stalled, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(
               apply_deque_request(dq_pkg::op_type'(req_operation), req_push_word));
            requests_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
               next_request = pending_requests.pop_front();
               req_valid     <= 1'b1;
               req_operation <= next_request.op;
               req_push_word <= next_request.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: response with none pending: pop_word=%h status=%0d fill_level=%0d",
                     $time, rsp_pop_word, rsp_status, rsp_fill_level);
            failures++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_pop_word !== want.pop_word) begin
               $display("%0t: pop_word expected %h actual %h", $time, want.pop_word,
                        rsp_pop_word);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               failures++;
            end
            if (rsp_fill_level !== want.fill_level) begin
               $display("%0t: fill_level expected %0d actual %0d", $time, want.fill_level,
                        rsp_fill_level);
               failures++;
            end
         end
      end
      rsp_stall <= !reset && ($urandom_range(99, 0) < receiver_idle_pct);
   end

   // Watchdog: too long without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule

// ===== double_ended_queue_top.f =====
hdl/dq_pkg.sv
hdl/dq_cell.sv
hdl/double_ended_queue_top.sv
verif/tb.sv
